FILE: hw/rtl/acs_pkg.sv
package acs_pkg;

    localparam int CP_W     = 21;
    localparam int LETTER_W = 6;
    localparam int MARK_W   = 11;
    localparam int MCNT_W   = 6;

    localparam logic [CP_W-1:0] CP_FIRST_LETTER = 21'h000621;
    localparam logic [CP_W-1:0] CP_LAST_LETTER  = 21'h00064A;
    localparam logic [CP_W-1:0] CP_TATWEEL      = 21'h000640;
    localparam logic [CP_W-1:0] CP_ALEF_MADDA   = 21'h000622;
    localparam logic [CP_W-1:0] CP_ALEF_HAMZA_A = 21'h000623;
    localparam logic [CP_W-1:0] CP_ALEF_HAMZA_B = 21'h000625;
    localparam logic [CP_W-1:0] CP_ALEF         = 21'h000627;
    localparam logic [15:0]     LIG_MADDA       = 16'hFEF5;
    localparam logic [15:0]     LIG_HAMZA_A     = 16'hFEF7;
    localparam logic [15:0]     LIG_HAMZA_B     = 16'hFEF9;
    localparam logic [15:0]     LIG_ALEF        = 16'hFEFB;
    localparam logic [LETTER_W-1:0] LAM_INDEX   = 6'h23;

    typedef enum logic [2:0] {
        JC_U = 3'd0,
        JC_D = 3'd1,
        JC_R = 3'd2,
        JC_C = 3'd3,
        JC_T = 3'd4
    } jclass_t;

    typedef struct packed {
        logic              lead_valid;
        logic [CP_W-1:0]   lead_code;
        logic [MCNT_W-1:0] mark_count;
        logic              mark_bank;
        logic              tail_valid;
        logic [CP_W-1:0]   tail_code;
        logic              dropped;
        logic              text_end;
    } shp_cmd_t;

    typedef struct packed {
        logic release_done;
        logic bank;
    } bank_stat_t;

    function automatic logic [15:0] letter_iso(input logic [LETTER_W-1:0] idx);
        logic [15:0] iso;
        unique case (idx)
            6'd0:  iso = 16'hFE80;
            6'd1:  iso = 16'hFE81;
            6'd2:  iso = 16'hFE83;
            6'd3:  iso = 16'hFE85;
            6'd4:  iso = 16'hFE87;
            6'd5:  iso = 16'hFE89;
            6'd6:  iso = 16'hFE8D;
            6'd7:  iso = 16'hFE8F;
            6'd8:  iso = 16'hFE93;
            6'd9:  iso = 16'hFE95;
            6'd10: iso = 16'hFE99;
            6'd11: iso = 16'hFE9D;
            6'd12: iso = 16'hFEA1;
            6'd13: iso = 16'hFEA5;
            6'd14: iso = 16'hFEA9;
            6'd15: iso = 16'hFEAB;
            6'd16: iso = 16'hFEAD;
            6'd17: iso = 16'hFEAF;
            6'd18: iso = 16'hFEB1;
            6'd19: iso = 16'hFEB5;
            6'd20: iso = 16'hFEB9;
            6'd21: iso = 16'hFEBD;
            6'd22: iso = 16'hFEC1;
            6'd23: iso = 16'hFEC5;
            6'd24: iso = 16'hFEC9;
            6'd25: iso = 16'hFECD;
            6'd32: iso = 16'hFED1;
            6'd33: iso = 16'hFED5;
            6'd34: iso = 16'hFED9;
            6'd35: iso = 16'hFEDD;
            6'd36: iso = 16'hFEE1;
            6'd37: iso = 16'hFEE5;
            6'd38: iso = 16'hFEE9;
            6'd39: iso = 16'hFEED;
            6'd40: iso = 16'hFEEF;
            6'd41: iso = 16'hFEF1;
            default: iso = 16'h0000;
        endcase
        return iso;
    endfunction

    function automatic jclass_t letter_cls(input logic [LETTER_W-1:0] idx);
        jclass_t cls;
        unique case (idx)
            6'd1, 6'd2, 6'd3, 6'd4, 6'd6, 6'd8,
            6'd14, 6'd15, 6'd16, 6'd17, 6'd39, 6'd40: cls = JC_R;
            6'd5, 6'd7, 6'd9, 6'd10, 6'd11, 6'd12, 6'd13,
            6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
            6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd41: cls = JC_D;
            default: cls = JC_U;
        endcase
        return cls;
    endfunction

    function automatic logic is_mark(input logic [CP_W-1:0] c);
        return (c >= 21'h00064B && c <= 21'h00065F) || c == 21'h000670 ||
               (c >= 21'h0006D6 && c <= 21'h0006DC) ||
               (c >= 21'h0006DF && c <= 21'h0006E4) ||
               c == 21'h0006E7 || c == 21'h0006E8 ||
               (c >= 21'h0006EA && c <= 21'h0006ED);
    endfunction

    function automatic jclass_t class_of(input logic [CP_W-1:0] c);
        logic [CP_W-1:0] off;
        jclass_t         cls;
        off = c - CP_FIRST_LETTER;
        if (is_mark(c))
            cls = JC_T;
        else if (c == CP_TATWEEL)
            cls = JC_C;
        else if (c >= CP_FIRST_LETTER && c <= CP_LAST_LETTER)
            cls = letter_cls(off[LETTER_W-1:0]);
        else
            cls = JC_U;
        return cls;
    endfunction

    function automatic logic [CP_W-1:0] pick_form(input logic [LETTER_W-1:0] idx,
                                                  input logic joins_back,
                                                  input logic after);
        logic [15:0] iso;
        jclass_t     cls;
        logic [1:0]  off;
        iso = letter_iso(idx);
        cls = letter_cls(idx);
        off = 2'd0;
        if (cls == JC_D)
            off = {after, joins_back};
        else if (cls == JC_R && joins_back && !after)
            off = 2'd1;
        return CP_W'(iso + 16'(off));
    endfunction

    function automatic logic [CP_W-1:0] lig_of(input logic [CP_W-1:0] c,
                                               input logic joins_back);
        logic [15:0] base;
        unique case (c)
            CP_ALEF_MADDA:   base = LIG_MADDA;
            CP_ALEF_HAMZA_A: base = LIG_HAMZA_A;
            CP_ALEF_HAMZA_B: base = LIG_HAMZA_B;
            CP_ALEF:         base = LIG_ALEF;
            default:         base = 16'h0000;
        endcase
        return (base == 16'h0000) ? '0 : CP_W'(base + 16'(joins_back));
    endfunction

endpackage

FILE: hw/rtl/acs_ram.sv
module acs_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hw/rtl/acs_front.sv
module acs_front
    import acs_pkg::*;
#(
    parameter int MARK_DEPTH = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [CP_W-1:0]                     code_point,
    input  logic                                string_end,
    input  logic                                item_valid,
    output logic                                item_ready,
    output shp_cmd_t                            cmd,
    output logic                                cmd_push,
    input  logic                                fifo_full,
    input  bank_stat_t                          stat,
    output logic                                ram_we,
    output logic [$clog2(2*MARK_DEPTH)-1:0]     ram_waddr,
    output logic [MARK_W-1:0]                   ram_wdata
);

    localparam int CW = $clog2(MARK_DEPTH + 1);
    localparam int AW = $clog2(2 * MARK_DEPTH);

    logic [LETTER_W-1:0] held_letter_reg, held_letter_next;
    logic                held_valid_reg, held_valid_next;
    logic                held_before_reg, held_before_next;
    logic                prior_joins_reg, prior_joins_next;
    logic [CW-1:0]       mark_cnt_reg, mark_cnt_next;
    logic                drop_reg, drop_next;
    logic                bank_reg, bank_next;
    logic [1:0]          busy_reg, busy_next;

    jclass_t             cls;
    logic [CP_W-1:0]     letter_off;
    logic [LETTER_W-1:0] letter_idx;
    logic [CP_W-1:0]     lig_code;
    logic                accept;
    logic                buf_full;
    logic                joins_fwd;
    logic                lig_hit;
    logic                consumed;
    logic [CW-1:0]       cnt_after;
    logic                drop_after;

    always_comb
    begin
        cls        = class_of(code_point);
        letter_off = code_point - CP_FIRST_LETTER;
        letter_idx = letter_off[LETTER_W-1:0];
        lig_code   = lig_of(code_point, held_before_reg);
        item_ready = !fifo_full && !(held_valid_reg && busy_reg[bank_reg]);
        accept     = item_valid && item_ready;
        buf_full   = (mark_cnt_reg == CW'(MARK_DEPTH));
        joins_fwd  = (cls == JC_D) || (cls == JC_R) || (cls == JC_C);
        lig_hit    = held_valid_reg && (held_letter_reg == LAM_INDEX) &&
                     (mark_cnt_reg == '0) && (lig_code != '0);
        cnt_after  = buf_full ? mark_cnt_reg : mark_cnt_reg + CW'(1);
        drop_after = drop_reg || buf_full;
        consumed   = 1'b0;

        held_letter_next = held_letter_reg;
        held_valid_next  = held_valid_reg;
        held_before_next = held_before_reg;
        prior_joins_next = prior_joins_reg;
        mark_cnt_next    = mark_cnt_reg;
        drop_next        = drop_reg;
        bank_next        = bank_reg;

        cmd           = '0;
        cmd.mark_bank = bank_reg;
        cmd.text_end  = string_end;

        ram_we    = 1'b0;
        ram_waddr = bank_reg ? AW'(MARK_DEPTH) + AW'(mark_cnt_reg) : AW'(mark_cnt_reg);
        ram_wdata = code_point[MARK_W-1:0];

        if (accept)
        begin
            if (cls == JC_T)
            begin
                if (held_valid_reg)
                begin
                    ram_we        = !buf_full;
                    mark_cnt_next = cnt_after;
                    drop_next     = drop_after;
                    if (string_end)
                    begin
                        cmd.lead_valid  = 1'b1;
                        cmd.lead_code   = pick_form(held_letter_reg, held_before_reg, 1'b0);
                        cmd.mark_count  = MCNT_W'(cnt_after);
                        cmd.dropped     = drop_after;
                        held_valid_next = 1'b0;
                        mark_cnt_next   = '0;
                    end
                end
                else
                begin
                    cmd.tail_valid = 1'b1;
                    cmd.tail_code  = code_point;
                end
            end
            else
            begin
                if (held_valid_reg)
                begin
                    cmd.lead_valid  = 1'b1;
                    cmd.dropped     = drop_reg;
                    held_valid_next = 1'b0;
                    mark_cnt_next   = '0;
                    drop_next       = 1'b0;
                    if (lig_hit)
                    begin
                        cmd.lead_code    = lig_code;
                        consumed         = 1'b1;
                        prior_joins_next = 1'b0;
                    end
                    else
                    begin
                        cmd.lead_code  = pick_form(held_letter_reg, held_before_reg, joins_fwd);
                        cmd.mark_count = MCNT_W'(mark_cnt_reg);
                    end
                end
                if (!consumed)
                begin
                    priority if (cls == JC_D)
                    begin
                        if (string_end)
                        begin
                            cmd.tail_valid = 1'b1;
                            cmd.tail_code  = pick_form(letter_idx, prior_joins_reg, 1'b0);
                        end
                        else
                        begin
                            held_letter_next = letter_idx;
                            held_valid_next  = 1'b1;
                            held_before_next = prior_joins_reg;
                            mark_cnt_next    = '0;
                            drop_next        = 1'b0;
                            bank_next        = !bank_reg;
                        end
                    end
                    else if (cls == JC_R)
                    begin
                        cmd.tail_valid = 1'b1;
                        cmd.tail_code  = pick_form(letter_idx, prior_joins_reg, 1'b0);
                    end
                    else
                    begin
                        cmd.tail_valid = 1'b1;
                        cmd.tail_code  = code_point;
                    end
                    prior_joins_next = (cls == JC_D) || (cls == JC_C);
                end
            end
            if (string_end)
            begin
                prior_joins_next = 1'b0;
                drop_next        = 1'b0;
            end
        end

        cmd_push = accept && (cmd.lead_valid || cmd.tail_valid);

        busy_next = busy_reg;
        if (stat.release_done)
        begin
            busy_next[stat.bank] = 1'b0;
        end
        if (cmd_push && cmd.mark_count != '0)
        begin
            busy_next[cmd.mark_bank] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_letter_reg <= '0;
            held_valid_reg  <= 1'b0;
            held_before_reg <= 1'b0;
            prior_joins_reg <= 1'b0;
            mark_cnt_reg    <= '0;
            drop_reg        <= 1'b0;
            bank_reg        <= 1'b0;
            busy_reg        <= '0;
        end
        else
        begin
            held_letter_reg <= held_letter_next;
            held_valid_reg  <= held_valid_next;
            held_before_reg <= held_before_next;
            prior_joins_reg <= prior_joins_next;
            mark_cnt_reg    <= mark_cnt_next;
            drop_reg        <= drop_next;
            bank_reg        <= bank_next;
            busy_reg        <= busy_next;
        end
    end

    a_no_write_busy_bank: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !busy_reg[bank_reg])
        else $error("mark written into a bank still being drained");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mark_cnt_reg <= CW'(MARK_DEPTH))
        else $error("held mark count beyond buffer depth");

endmodule

FILE: hw/rtl/acs_cmd_fifo.sv
module acs_cmd_fifo
    import acs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  shp_cmd_t push_cmd,
    output logic     full,
    input  logic     pop,
    output shp_cmd_t head,
    output logic     empty
);

    shp_cmd_t   slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    always_comb
    begin
        full        = (cnt_reg == 2'd2);
        empty       = (cnt_reg == 2'd0);
        head        = slot_reg[rd_ptr_reg];
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("command queue overflow");

endmodule

FILE: hw/rtl/acs_back.sv
module acs_back
    import acs_pkg::*;
#(
    parameter int MARK_DEPTH = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  shp_cmd_t                        head,
    input  logic                            empty,
    output logic                            pop,
    output bank_stat_t                      stat,
    output logic                            rd_en,
    output logic [$clog2(2*MARK_DEPTH)-1:0] rd_addr,
    input  logic [MARK_W-1:0]               rd_data,
    output logic                            shaped_valid,
    input  logic                            shaped_ready,
    output logic [CP_W-1:0]                 shaped_point,
    output logic                            run_last,
    output logic                            text_last,
    output logic                            mark_dropped
);

    localparam int AW = $clog2(2 * MARK_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEAD,
        S_MREQ,
        S_MWAIT,
        S_TAIL
    } state_t;

    state_t            state_reg, state_next;
    shp_cmd_t          cmd_reg, cmd_next;
    logic [MCNT_W-1:0] idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    logic [CP_W-1:0]   shaped_reg, shaped_next;
    logic              run_last_reg, run_last_next;
    logic              text_last_reg, text_last_next;
    logic              dropped_reg, dropped_next;

    logic              out_free;
    logic              last_mark;
    logic [MCNT_W-1:0] rd_idx;

    always_comb
    begin
        out_free  = !out_valid_reg || shaped_ready;
        last_mark = ({1'b0, idx_reg} + (MCNT_W+1)'(1)) == {1'b0, cmd_reg.mark_count};

        state_next     = state_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !shaped_ready;
        shaped_next    = shaped_reg;
        run_last_next  = run_last_reg;
        text_last_next = text_last_reg;
        dropped_next   = dropped_reg;

        pop    = 1'b0;
        rd_en  = 1'b0;
        rd_idx = idx_reg;
        stat   = '0;
        stat.bank = cmd_reg.mark_bank;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    pop      = 1'b1;
                    cmd_next = head;
                    idx_next = '0;
                    priority if (head.lead_valid)
                        state_next = S_LEAD;
                    else if (head.mark_count != '0)
                        state_next = S_MREQ;
                    else
                        state_next = S_TAIL;
                end
            end
            S_LEAD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    shaped_next    = cmd_reg.lead_code;
                    run_last_next  = (cmd_reg.mark_count == '0) && !cmd_reg.tail_valid;
                    text_last_next = run_last_next && cmd_reg.text_end;
                    dropped_next   = cmd_reg.dropped;
                    priority if (cmd_reg.mark_count != '0)
                        state_next = S_MREQ;
                    else if (cmd_reg.tail_valid)
                        state_next = S_TAIL;
                    else
                        state_next = S_IDLE;
                end
            end
            S_MREQ:
            begin
                rd_en      = 1'b1;
                state_next = S_MWAIT;
            end
            S_MWAIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    shaped_next    = CP_W'(rd_data);
                    run_last_next  = last_mark && !cmd_reg.tail_valid;
                    text_last_next = run_last_next && cmd_reg.text_end;
                    dropped_next   = cmd_reg.dropped;
                    if (last_mark)
                    begin
                        stat.release_done = 1'b1;
                        state_next = cmd_reg.tail_valid ? S_TAIL : S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + MCNT_W'(1);
                        rd_en    = 1'b1;
                        rd_idx   = idx_next;
                    end
                end
            end
            S_TAIL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    shaped_next    = cmd_reg.tail_code;
                    run_last_next  = 1'b1;
                    text_last_next = cmd_reg.text_end;
                    dropped_next   = cmd_reg.dropped;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        rd_addr = cmd_reg.mark_bank ? AW'(MARK_DEPTH) + AW'(rd_idx) : AW'(rd_idx);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        shaped_reg    <= shaped_next;
        run_last_reg  <= run_last_next;
        text_last_reg <= text_last_next;
        dropped_reg   <= dropped_next;
    end

    assign shaped_valid = out_valid_reg;
    assign shaped_point = shaped_reg;
    assign run_last     = run_last_reg;
    assign text_last    = text_last_reg;
    assign mark_dropped = dropped_reg;

    a_marks_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MREQ || state_reg == S_MWAIT) |-> idx_reg < cmd_reg.mark_count)
        else $error("mark index beyond group size");

    a_text_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && text_last_reg) |-> run_last_reg)
        else $error("string end on a beat that does not close its item");

endmodule

FILE: hw/rtl/arabic_contextual_shaper.sv
// Channel   Valid          Ready          Payload
// item      item_valid     item_ready     code_point, string_end
// shaped    shaped_valid   shaped_ready   shaped_point, run_last, text_last, mark_dropped
//
// The front classifies one item per cycle, while item_ready is high, into a two-entry command queue.
// The back plays each command out one beat per cycle while shaped_ready allows, plus an
// idle state that pops the command and a request state before each group of held marks.
// Reset clears all control state at once; the mark RAM needs no clearing pass.
// item_ready drops when the queue is full or the held group's RAM bank is still draining.
module arabic_contextual_shaper
    import acs_pkg::*;
#(
    parameter int MARK_DEPTH = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_ready,
    input  logic [CP_W-1:0] code_point,
    input  logic            string_end,
    output logic            shaped_valid,
    input  logic            shaped_ready,
    output logic [CP_W-1:0] shaped_point,
    output logic            run_last,
    output logic            text_last,
    output logic            mark_dropped
);

    localparam int AW = $clog2(2 * MARK_DEPTH);

    shp_cmd_t          push_cmd;
    shp_cmd_t          head;
    logic              cmd_push;
    logic              fifo_full;
    logic              fifo_empty;
    logic              fifo_pop;
    bank_stat_t        stat;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [MARK_W-1:0] ram_wdata;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [MARK_W-1:0] rd_data;

    acs_front #(
        .MARK_DEPTH (MARK_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .code_point (code_point),
        .string_end (string_end),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .cmd        (push_cmd),
        .cmd_push   (cmd_push),
        .fifo_full  (fifo_full),
        .stat       (stat),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata)
    );

    acs_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_push),
        .push_cmd (push_cmd),
        .full     (fifo_full),
        .pop      (fifo_pop),
        .head     (head),
        .empty    (fifo_empty)
    );

    acs_ram #(
        .WIDTH (MARK_W),
        .DEPTH (2 * MARK_DEPTH)
    ) u_mark_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .rd_en (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    acs_back #(
        .MARK_DEPTH (MARK_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .empty        (fifo_empty),
        .pop          (fifo_pop),
        .stat         (stat),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .shaped_valid (shaped_valid),
        .shaped_ready (shaped_ready),
        .shaped_point (shaped_point),
        .run_last     (run_last),
        .text_last    (text_last),
        .mark_dropped (mark_dropped)
    );

endmodule
